// File: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Types, constants and helper functions shared by the mip texture sampler.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int SLOTS_DEF           = 4;
  localparam int LEVELS_DEF          = 3;
  localparam int BASE_SIZE_LOG2_DEF  = 7;
  localparam int COORD_FRAC_BITS_DEF = 8;

  localparam int LOD_FRAC_W = 8;
  localparam int MUL_B_W    = 17;
  localparam int MAX_LEVELS = 7;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [15:0] LOD_ONE   = 16'd256;
  localparam logic [15:0] MIX_SCALE = 16'd100;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOD_NORM,
    ST_LOD_SQ,
    ST_LOD_SQW,
    ST_LOD_FIN,
    ST_SRD,
    ST_TOP,
    ST_TOPW,
    ST_BOT,
    ST_BOTW,
    ST_VAL,
    ST_VALW,
    ST_MIX,
    ST_MIXW,
    ST_OUT,
    ST_BRD,
    ST_BWR
  } mts_state_t;

  // 565 channel widened to 8 bits by bit replication
  function automatic logic [7:0] mts_chan8(input logic [15:0] w, input logic [1:0] c);
    logic [7:0] r;
    case (c)
      2'd0:    r = {w[15:11], w[15:13]};
      2'd1:    r = {w[10:5], w[10:9]};
      default: r = {w[4:0], w[4:2]};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] mts_pack565(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [3:0] mts_lvl_log2(input logic [2:0] l, input int bl);
    logic [3:0] s;
    s = (int'(l) < bl) ? 4'(bl - int'(l)) : 4'd0;
    return s;
  endfunction

  // word offset of a level inside its slot
  function automatic logic [31:0] mts_lvl_off(input logic [2:0] l, input int bl);
    logic [31:0] off;
    off = 32'd0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (k < int'(l)) begin
        off = off + (32'd1 << (2 * mts_lvl_log2(3'(k), bl)));
      end
    end
    return off;
  endfunction

  function automatic logic [3:0] mts_msb16(input logic [15:0] f);
    logic [3:0] m;
    m = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (f[i]) begin
        m = 4'(i);
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/core/mts_ifs.sv
// ----------------------------------------------------------------------------
// mts_ifs
// Valid/ready channel interfaces for sampler requests and filtered colours.
// ----------------------------------------------------------------------------
interface mts_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [1:0]         texture_slot;
  logic [13:0]        texel_index;
  logic [15:0]        texel_word;
  logic signed [23:0] u_coord;
  logic signed [23:0] v_coord;
  logic [15:0]        footprint;

  modport source (output valid, operation, texture_slot, texel_index, texel_word,
                  u_coord, v_coord, footprint, input ready);
  modport sink (input valid, operation, texture_slot, texel_index, texel_word,
                u_coord, v_coord, footprint, output ready);
endinterface

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// File: rtl/core/mip_texture_trilinear_sampler_top.sv
// ----------------------------------------------------------------------------
// mip_texture_trilinear_sampler_top
// Trilinear mip-mapped RGB565 texture unit with in-place mip chain build.
// ----------------------------------------------------------------------------
// One request at a time. A texel write goes to memory in the cycle it is
// accepted. A sample works on a single level or blends across two levels:
// eight squaring steps for the level of detail (skipped when the footprint is
// 1.0 or less), four texel reads per level from the single read port, and nine
// multiplies per level plus three for the blend, all on one shared multiplier.
// A build does four reads per destination texel, takes in the last read data,
// then writes the averaged texel. A result waiting at the output does not stop
// the next request being taken. Texels never written read as garbage.
// ----------------------------------------------------------------------------
module mip_texture_trilinear_sampler_top
  import mts_pkg::*;
#(
  parameter int SLOTS           = SLOTS_DEF,
  parameter int LEVELS          = LEVELS_DEF,
  parameter int BASE_SIZE_LOG2  = BASE_SIZE_LOG2_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);
  localparam int BL        = BASE_SIZE_LOG2;
  localparam int F         = COORD_FRAC_BITS;
  localparam int AREA_LOG2 = 2 * BL;
  localparam int DEPTH     = SLOTS << (AREA_LOG2 + 1);
  localparam int AW        = $clog2(DEPTH);
  localparam int LW        = $clog2(LEVELS + 1);
  localparam int TW        = F + 9;
  localparam int MAW       = (F + 10 > MUL_B_W) ? F + 10 : MUL_B_W;
  localparam int PW        = MAW + MUL_B_W;
  localparam int VW        = 2 * F + 9;

  mts_state_t state_r, state_nxt;

  logic [1:0]         slot_r, slot_nxt;
  logic signed [23:0] u_r, u_nxt, v_r, v_nxt;
  logic [15:0]        fp_r, fp_nxt;
  logic [3:0]         msb_r, msb_nxt;
  logic [15:0]        m_r, m_nxt;
  logic [7:0]         frac_r, frac_nxt;
  logic [2:0]         it_r, it_nxt;
  logic [LW-1:0]      lv_r, lv_nxt, cur_l_r, cur_l_nxt, lvl_r, lvl_nxt;
  logic [7:0]         fr_r, fr_nxt;
  logic               mix_r, mix_nxt, pass_r, pass_nxt;
  logic [2:0]         rk_r, rk_nxt;
  logic [1:0]         c_r, c_nxt;
  logic [15:0]        tex_r [4];
  logic [15:0]        tex_nxt [4];
  logic [7:0]         a_r [3];
  logic [7:0]         a_nxt [3];
  logic [7:0]         b_r [3];
  logic [7:0]         b_nxt [3];
  logic [9:0]         acc_r [3];
  logic [9:0]         acc_nxt [3];
  logic [TW-1:0]      top_r, top_nxt, bot_r, bot_nxt;
  logic [BL-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  logic signed [MAW-1:0]     mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]      prod;

  logic               accept, in_slot_ok, in_idx_ok, out_free;
  logic [AW-1:0]      slot_base, in_addr, samp_addr, src_addr, dst_addr;
  logic [3:0]         cur_s, bs, bd;
  logic [BL-1:0]      cmask, smask, dlast, u0, u1, v0, v1, bx, by;
  logic signed [23:0] uu, vv;
  logic [F-1:0]       fu, fv;
  logic [LW-1:0]      src_l;
  logic               bot_phase;
  logic [7:0]         ch_lo, ch_hi, ca, cb, diffm, q;
  logic signed [8:0]  d9;
  logic signed [TW-1:0] dtb;
  logic [16:0]        sq;
  logic [10:0]        lod_raw, lod_max, lod_c;
  logic [VW-1:0]      val;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_slot_ok = int'(in_ch.texture_slot) < SLOTS;
  assign in_idx_ok  = 32'(in_ch.texel_index) < (32'd1 << AREA_LOG2);
  assign out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  // addressing
  assign slot_base = AW'(slot_r) << (AREA_LOG2 + 1);
  assign in_addr   = (AW'(in_ch.texture_slot) << (AREA_LOG2 + 1)) + AW'(in_ch.texel_index);

  assign cur_s = mts_lvl_log2(3'(cur_l_r), BL);
  assign cmask = BL'((32'd1 << cur_s) - 32'd1);
  assign uu    = u_r >>> cur_l_r;
  assign vv    = v_r >>> cur_l_r;
  assign fu    = uu[F-1:0];
  assign fv    = vv[F-1:0];
  assign u0    = uu[F +: BL] & cmask;
  assign v0    = vv[F +: BL] & cmask;
  assign u1    = (u0 + BL'(1)) & cmask;
  assign v1    = (v0 + BL'(1)) & cmask;
  assign samp_addr = slot_base + AW'(mts_lvl_off(3'(cur_l_r), BL))
                   + (AW'(rk_r[1] ? v1 : v0) << cur_s) + AW'(rk_r[0] ? u1 : u0);

  assign src_l = lvl_r - LW'(1);
  assign bs    = mts_lvl_log2(3'(src_l), BL);
  assign bd    = mts_lvl_log2(3'(lvl_r), BL);
  assign smask = BL'((32'd1 << bs) - 32'd1);
  assign dlast = BL'((32'd1 << bd) - 32'd1);
  assign bx    = ((x_r << 1) | BL'(rk_r[0])) & smask;
  assign by    = ((y_r << 1) | BL'(rk_r[1])) & smask;
  assign src_addr = slot_base + AW'(mts_lvl_off(3'(src_l), BL)) + (AW'(by) << bs) + AW'(bx);
  assign dst_addr = slot_base + AW'(mts_lvl_off(3'(lvl_r), BL)) + (AW'(y_r) << bd) + AW'(x_r);

  assign ram_raddr = (state_r == ST_BRD) ? src_addr : samp_addr;

  // channel operands
  assign bot_phase = (state_r == ST_BOT) || (state_r == ST_BOTW);
  assign ch_lo = mts_chan8(bot_phase ? tex_r[2] : tex_r[0], c_r);
  assign ch_hi = mts_chan8(bot_phase ? tex_r[3] : tex_r[1], c_r);
  assign d9    = signed'({1'b0, ch_hi}) - signed'({1'b0, ch_lo});
  assign dtb   = signed'(bot_r - top_r);
  assign ca    = a_r[c_r];
  assign cb    = b_r[c_r];
  assign diffm = (cb >= ca) ? cb - ca : ca - cb;
  assign q     = prod[15:8];
  assign sq    = prod[31:15];
  assign val   = (VW'(top_r) << F) + VW'(prod);

  assign lod_raw = {3'(msb_r - 4'd8), frac_r};
  assign lod_max = 11'(LEVELS) << LOD_FRAC_W;
  assign lod_c   = (lod_raw > lod_max) ? lod_max : lod_raw;

  always_comb begin
    unique case (state_r)
      ST_LOD_SQ: begin
        mul_a = MAW'(m_r);
        mul_b = MUL_B_W'(m_r);
      end
      ST_TOP, ST_BOT: begin
        mul_a = MAW'(d9);
        mul_b = MUL_B_W'(fu);
      end
      ST_VAL: begin
        mul_a = MAW'(dtb);
        mul_b = MUL_B_W'(fv);
      end
      ST_MIX: begin
        mul_a = MAW'(diffm);
        mul_b = MUL_B_W'(fr_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mts_mul #(.A_W(MAW), .B_W(MUL_B_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  mts_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.operation == OP_BUILD && in_slot_ok) begin
          state_nxt = ST_BRD;
        end else if (accept && in_ch.operation == OP_SAMPLE) begin
          state_nxt = in_slot_ok ? ST_LOD_NORM : ST_OUT;
        end
      end
      ST_LOD_NORM: state_nxt = (fp_r <= LOD_ONE) ? ST_SRD : ST_LOD_SQ;
      ST_LOD_SQ:   state_nxt = ST_LOD_SQW;
      ST_LOD_SQW:  state_nxt = (it_r == 3'd7) ? ST_LOD_FIN : ST_LOD_SQ;
      ST_LOD_FIN:  state_nxt = ST_SRD;
      ST_SRD:      state_nxt = (rk_r == 3'd4) ? ST_TOP : ST_SRD;
      ST_TOP:      state_nxt = ST_TOPW;
      ST_TOPW:     state_nxt = ST_BOT;
      ST_BOT:      state_nxt = ST_BOTW;
      ST_BOTW:     state_nxt = ST_VAL;
      ST_VAL:      state_nxt = ST_VALW;
      ST_VALW: begin
        if (c_r != 2'd2) begin
          state_nxt = ST_TOP;
        end else if (pass_r) begin
          state_nxt = ST_MIX;
        end else begin
          state_nxt = mix_r ? ST_SRD : ST_OUT;
        end
      end
      ST_MIX:  state_nxt = ST_MIXW;
      ST_MIXW: state_nxt = (c_r == 2'd2) ? ST_OUT : ST_MIX;
      ST_OUT:  state_nxt = out_free ? ST_IDLE : ST_OUT;
      ST_BRD:  state_nxt = (rk_r == 3'd4) ? ST_BWR : ST_BRD;
      ST_BWR: begin
        if (x_r == dlast && y_r == dlast && int'(lvl_r) == LEVELS) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_BRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    slot_nxt  = slot_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    fp_nxt    = fp_r;
    msb_nxt   = msb_r;
    m_nxt     = m_r;
    frac_nxt  = frac_r;
    it_nxt    = it_r;
    lv_nxt    = lv_r;
    cur_l_nxt = cur_l_r;
    lvl_nxt   = lvl_r;
    fr_nxt    = fr_r;
    mix_nxt   = mix_r;
    pass_nxt  = pass_r;
    rk_nxt    = rk_r;
    c_nxt     = c_r;
    tex_nxt   = tex_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_we    = 1'b0;
    ram_waddr = dst_addr;
    ram_wdata = mts_pack565(acc_r[0][9:2], acc_r[1][9:2], acc_r[2][9:2]);

    unique case (state_r)
      ST_IDLE: begin
        slot_nxt = in_ch.texture_slot;
        u_nxt    = in_ch.u_coord;
        v_nxt    = in_ch.v_coord;
        fp_nxt   = in_ch.footprint;
        lvl_nxt  = LW'(1);
        x_nxt    = '0;
        y_nxt    = '0;
        rk_nxt   = '0;
        a_nxt    = '{default: 8'd0};
        if (accept && in_ch.operation == OP_WRITE && in_slot_ok && in_idx_ok) begin
          ram_we    = 1'b1;
          ram_waddr = in_addr;
          ram_wdata = in_ch.texel_word;
        end
      end
      ST_LOD_NORM: begin
        msb_nxt   = mts_msb16(fp_r);
        m_nxt     = 16'(fp_r << (4'd15 - mts_msb16(fp_r)));
        it_nxt    = '0;
        lv_nxt    = '0;
        cur_l_nxt = '0;
        fr_nxt    = '0;
        mix_nxt   = 1'b0;
        pass_nxt  = 1'b0;
        rk_nxt    = '0;
        c_nxt     = '0;
      end
      ST_LOD_SQW: begin
        frac_nxt = {frac_r[6:0], sq[16]};
        m_nxt    = sq[16] ? sq[16:1] : sq[15:0];
        it_nxt   = it_r + 3'd1;
      end
      ST_LOD_FIN: begin
        lv_nxt    = LW'(lod_c[10:8]);
        cur_l_nxt = LW'(lod_c[10:8]);
        fr_nxt    = lod_c[7:0];
        mix_nxt   = (16'(lod_c[7:0]) * MIX_SCALE > LOD_ONE) && (int'(lod_c[10:8]) < LEVELS);
      end
      ST_SRD: begin
        if (rk_r != 3'd0) begin
          tex_nxt[2'(rk_r - 3'd1)] = ram_rdata;
        end
        rk_nxt = rk_r + 3'd1;
        c_nxt  = '0;
      end
      ST_TOPW: top_nxt = (TW'(ch_lo) << F) + TW'(prod);
      ST_BOTW: bot_nxt = (TW'(ch_lo) << F) + TW'(prod);
      ST_VALW: begin
        if (pass_r) begin
          b_nxt[c_r] = val[2*F +: 8];
        end else begin
          a_nxt[c_r] = val[2*F +: 8];
        end
        c_nxt = c_r + 2'd1;
        if (c_r == 2'd2) begin
          c_nxt     = '0;
          rk_nxt    = '0;
          pass_nxt  = 1'b1;
          cur_l_nxt = lv_r + LW'(1);
        end
      end
      ST_MIXW: begin
        a_nxt[c_r] = (cb >= ca) ? ca + q : ca - q;
        c_nxt      = c_r + 2'd1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          red_nxt       = a_r[0];
          green_nxt     = a_r[1];
          blue_nxt      = a_r[2];
        end
      end
      ST_BRD: begin
        for (int i = 0; i < 3; i++) begin
          if (rk_r == 3'd1) begin
            acc_nxt[i] = 10'(mts_chan8(ram_rdata, 2'(i)));
          end else if (rk_r != 3'd0) begin
            acc_nxt[i] = acc_r[i] + 10'(mts_chan8(ram_rdata, 2'(i)));
          end
        end
        rk_nxt = rk_r + 3'd1;
      end
      ST_BWR: begin
        ram_we = 1'b1;
        rk_nxt = '0;
        x_nxt  = x_r + BL'(1);
        if (x_r == dlast) begin
          x_nxt = '0;
          y_nxt = y_r + BL'(1);
          if (y_r == dlast) begin
            y_nxt   = '0;
            lvl_nxt = lvl_r + LW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    fp_r    <= fp_nxt;
    msb_r   <= msb_nxt;
    m_r     <= m_nxt;
    frac_r  <= frac_nxt;
    it_r    <= it_nxt;
    lv_r    <= lv_nxt;
    cur_l_r <= cur_l_nxt;
    lvl_r   <= lvl_nxt;
    fr_r    <= fr_nxt;
    mix_r   <= mix_nxt;
    pass_r  <= pass_nxt;
    rk_r    <= rk_nxt;
    c_r     <= c_nxt;
    tex_r   <= tex_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    top_r   <= top_nxt;
    bot_r   <= bot_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

`ifndef NO_ASSERTIONS
  a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE || state_r == ST_BWR))
    else $error("texture memory written outside a write or build transfer");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not presented after sequencing finished");

  a_build_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BRD || state_r == ST_BWR) |-> (lvl_r != '0 && int'(lvl_r) <= LEVELS))
    else $error("build level out of range");

  a_sample_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRD && pass_r) |-> (cur_l_r == lv_r + LW'(1) && mix_r))
    else $error("second level fetched without a blend");
`endif

endmodule

// File: rtl/core/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/mts_mul.sv
// ----------------------------------------------------------------------------
// mts_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module mts_mul #(
  parameter int A_W = 18,
  parameter int B_W = 17
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
